// File: rtl/core/skv_pkg.sv
// shared types and constants for the sph kernel value unit
package skv_pkg;

  localparam int NUM_LANES     = 3;
  localparam int NUM_STEPS     = 3;
  localparam int NORM_W        = 32;
  localparam int OUT_W         = 40;
  localparam int BASE_INT_BITS = 2;
  localparam int POW_INT_BITS  = 8;
  localparam int CFG_INDEX_W   = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_TYPE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_NORM_SCALE  = 1'b1;

  typedef enum logic [1:0] {
    K_CUBIC      = 2'd0,
    K_WENDLAND   = 2'd1,
    K_QUINTIC    = 2'd2,
    K_HYPERBOLIC = 2'd3
  } kernel_t;

  typedef enum logic [1:0] {
    R_LT1 = 2'd0,
    R_LT2 = 2'd1,
    R_LT3 = 2'd2,
    R_OUT = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    OP_PASS     = 2'd0,
    OP_SQUARE   = 2'd1,
    OP_MUL_BASE = 2'd2
  } lane_op_t;

  typedef lane_op_t [NUM_STEPS-1:0] op_seq_t;

  typedef struct packed {
    kernel_t                     kt;
    region_t                     region;
    op_seq_t [NUM_LANES-1:0]     ops;
  } skv_ctrl_t;

  // element 0 is the first step
  localparam op_seq_t SEQ_NONE   = '{OP_PASS, OP_PASS, OP_PASS};
  localparam op_seq_t SEQ_SQUARE = '{OP_PASS, OP_PASS, OP_SQUARE};
  localparam op_seq_t SEQ_CUBE   = '{OP_PASS, OP_MUL_BASE, OP_SQUARE};
  localparam op_seq_t SEQ_POW4   = '{OP_PASS, OP_SQUARE, OP_SQUARE};
  localparam op_seq_t SEQ_POW5   = '{OP_MUL_BASE, OP_SQUARE, OP_SQUARE};

endpackage

// File: rtl/core/skv_prep.sv
// input stage: region decode, lane bases and power sequences
module skv_prep #(
  parameter int FRAC_BITS     = 16,
  parameter int DIST_INT_BITS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [DIST_INT_BITS+FRAC_BITS-1:0] up_q,
  input  skv_pkg::kernel_t          kernel_type,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output skv_pkg::skv_ctrl_t        dn_ctrl,
  output logic [FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] dn_q,
  output logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] dn_base,
  output logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::POW_INT_BITS-1:0] dn_pow
);

  localparam int DIST_W = DIST_INT_BITS + FRAC_BITS;
  localparam int BASE_W = FRAC_BITS + skv_pkg::BASE_INT_BITS;
  localparam int POW_W  = FRAC_BITS + skv_pkg::POW_INT_BITS;
  localparam logic [BASE_W-1:0] ONE_FX   = BASE_W'(1) << FRAC_BITS;
  localparam logic [BASE_W-1:0] TWO_FX   = ONE_FX << 1;
  localparam logic [BASE_W-1:0] THREE_FX = ONE_FX + TWO_FX;

  logic [DIST_INT_BITS-1:0] int_part;
  logic [BASE_W-1:0]        qt;
  logic [BASE_W-1:0]        d_a;
  logic [BASE_W-1:0]        d_b;
  logic [BASE_W-1:0]        d_c;
  skv_pkg::region_t         region;
  skv_pkg::skv_ctrl_t       ctrl_next;
  logic [skv_pkg::NUM_LANES-1:0][BASE_W-1:0] base_next;

  assign int_part = up_q[DIST_W-1:FRAC_BITS];
  assign qt       = up_q[BASE_W-1:0];
  assign d_a      = THREE_FX - qt;
  assign d_b      = TWO_FX - qt;
  assign d_c      = ONE_FX - qt;

  always_comb begin
    if (int_part == '0) begin
      region = skv_pkg::R_LT1;
    end else if (int_part == DIST_INT_BITS'(1)) begin
      region = skv_pkg::R_LT2;
    end else if (int_part == DIST_INT_BITS'(2)) begin
      region = skv_pkg::R_LT3;
    end else begin
      region = skv_pkg::R_OUT;
    end
  end

  always_comb begin
    ctrl_next.kt     = kernel_type;
    ctrl_next.region = region;
    for (int l = 0; l < skv_pkg::NUM_LANES; l++) begin
      ctrl_next.ops[l] = skv_pkg::SEQ_NONE;
      base_next[l]     = '0;
    end
    case (kernel_type)
      skv_pkg::K_CUBIC: begin
        if (region == skv_pkg::R_LT1) begin
          base_next[0]     = qt;
          ctrl_next.ops[0] = skv_pkg::SEQ_SQUARE;
          base_next[1]     = qt;
          ctrl_next.ops[1] = skv_pkg::SEQ_CUBE;
        end else if (region == skv_pkg::R_LT2) begin
          base_next[0]     = d_b;
          ctrl_next.ops[0] = skv_pkg::SEQ_CUBE;
        end
      end
      skv_pkg::K_WENDLAND: begin
        if (region == skv_pkg::R_LT1 || region == skv_pkg::R_LT2) begin
          base_next[0]     = d_b;
          ctrl_next.ops[0] = skv_pkg::SEQ_POW4;
        end
      end
      skv_pkg::K_QUINTIC: begin
        for (int l = 0; l < skv_pkg::NUM_LANES; l++) begin
          ctrl_next.ops[l] = skv_pkg::SEQ_POW5;
        end
        if (region != skv_pkg::R_OUT) begin
          base_next[0] = d_a;
        end
        if (region == skv_pkg::R_LT1 || region == skv_pkg::R_LT2) begin
          base_next[1] = d_b;
        end
        if (region == skv_pkg::R_LT1) begin
          base_next[2] = d_c;
        end
      end
      skv_pkg::K_HYPERBOLIC: begin
        if (region == skv_pkg::R_LT1) begin
          base_next[0]     = qt;
          ctrl_next.ops[0] = skv_pkg::SEQ_CUBE;
        end else if (region == skv_pkg::R_LT2) begin
          base_next[0]     = d_b;
          ctrl_next.ops[0] = skv_pkg::SEQ_CUBE;
        end
      end
      default: begin
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_ctrl <= ctrl_next;
      dn_q    <= qt;
      for (int l = 0; l < skv_pkg::NUM_LANES; l++) begin
        dn_base[l] <= base_next[l];
        dn_pow[l]  <= POW_W'(base_next[l]);
      end
    end
  end

endmodule

// File: rtl/core/skv_cell.sv
// one multiply cell of the power chain: each lane squares, multiplies by its base or passes its power on
module skv_cell #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  skv_pkg::skv_ctrl_t up_ctrl,
  input  logic [FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] up_q,
  input  logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] up_base,
  input  logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::POW_INT_BITS-1:0] up_pow,
  output logic               dn_valid,
  input  logic               dn_ready,
  output skv_pkg::skv_ctrl_t dn_ctrl,
  output logic [FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] dn_q,
  output logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] dn_base,
  output logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::POW_INT_BITS-1:0] dn_pow
);

  localparam int POW_W  = FRAC_BITS + skv_pkg::POW_INT_BITS;
  localparam int PROD_W = 2 * POW_W;

  logic [skv_pkg::NUM_LANES-1:0][POW_W-1:0]  mult;
  logic [skv_pkg::NUM_LANES-1:0][PROD_W-1:0] prod;
  logic [skv_pkg::NUM_LANES-1:0][POW_W-1:0]  pow_next;
  skv_pkg::skv_ctrl_t                        ctrl_next;

  always_comb begin
    ctrl_next = up_ctrl;
    for (int l = 0; l < skv_pkg::NUM_LANES; l++) begin
      mult[l] = (up_ctrl.ops[l][0] == skv_pkg::OP_SQUARE) ? up_pow[l] : POW_W'(up_base[l]);
      prod[l] = PROD_W'(up_pow[l]) * PROD_W'(mult[l]);
      case (up_ctrl.ops[l][0])
        skv_pkg::OP_SQUARE,
        skv_pkg::OP_MUL_BASE: pow_next[l] = prod[l][FRAC_BITS +: POW_W];
        default:              pow_next[l] = up_pow[l];
      endcase
      for (int s = 0; s < skv_pkg::NUM_STEPS - 1; s++) begin
        ctrl_next.ops[l][s] = up_ctrl.ops[l][s+1];
      end
      ctrl_next.ops[l][skv_pkg::NUM_STEPS-1] = skv_pkg::OP_PASS;
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_ctrl <= ctrl_next;
      dn_q    <= up_q;
      dn_base <= up_base;
      dn_pow  <= pow_next;
    end
  end

endmodule

// File: rtl/core/skv_combine.sv
// combines lane powers into the kernel polynomial, clamped at zero
module skv_combine #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  skv_pkg::skv_ctrl_t up_ctrl,
  input  logic [FRAC_BITS+skv_pkg::BASE_INT_BITS-1:0] up_q,
  input  logic [skv_pkg::NUM_LANES-1:0][FRAC_BITS+skv_pkg::POW_INT_BITS-1:0] up_pow,
  output logic               dn_valid,
  input  logic               dn_ready,
  output logic [FRAC_BITS+skv_pkg::POW_INT_BITS-1:0] dn_poly
);

  localparam int BASE_W     = FRAC_BITS + skv_pkg::BASE_INT_BITS;
  localparam int POW_W      = FRAC_BITS + skv_pkg::POW_INT_BITS;
  localparam int SUM_W      = POW_W + 5;
  localparam int WEND_W     = POW_W + BASE_W + 1;
  localparam int WEND_SHIFT = FRAC_BITS + 4;
  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) <<< FRAC_BITS;
  localparam logic [BASE_W:0]         ONE_T = (BASE_W + 1)'(1) << FRAC_BITS;

  logic signed [SUM_W-1:0] p0;
  logic signed [SUM_W-1:0] p1;
  logic signed [SUM_W-1:0] p2;
  logic signed [SUM_W-1:0] qv;
  logic signed [SUM_W-1:0] s;
  logic [BASE_W:0]         wend_tq;
  logic [WEND_W-1:0]       wend_prod;
  logic [WEND_W-1:0]       wend_shift;
  logic [POW_W-1:0]        poly_next;

  assign p0         = $signed(SUM_W'(up_pow[0]));
  assign p1         = $signed(SUM_W'(up_pow[1]));
  assign p2         = $signed(SUM_W'(up_pow[2]));
  assign qv         = $signed(SUM_W'(up_q));
  assign wend_tq    = {up_q, 1'b0} + ONE_T;
  assign wend_prod  = WEND_W'(up_pow[0]) * WEND_W'(wend_tq);
  assign wend_shift = wend_prod >> WEND_SHIFT;

  always_comb begin
    s = '0;
    case (up_ctrl.kt)
      skv_pkg::K_CUBIC: begin
        if (up_ctrl.region == skv_pkg::R_LT1) begin
          s = ONE_S - ((p0 + (p0 <<< 1)) >>> 1) + ((p1 + (p1 <<< 1)) >>> 2);
        end else if (up_ctrl.region == skv_pkg::R_LT2) begin
          s = p0 >>> 2;
        end
      end
      skv_pkg::K_WENDLAND: begin
        if (up_ctrl.region == skv_pkg::R_LT1 || up_ctrl.region == skv_pkg::R_LT2) begin
          s = $signed(SUM_W'(wend_shift[POW_W-1:0]));
        end
      end
      skv_pkg::K_QUINTIC: begin
        s = p0 - ((p1 <<< 2) + (p1 <<< 1)) + ((p2 <<< 4) - p2);
      end
      skv_pkg::K_HYPERBOLIC: begin
        if (up_ctrl.region == skv_pkg::R_LT1) begin
          s = p0 + (ONE_S <<< 2) + (ONE_S <<< 1) - ((qv <<< 2) + (qv <<< 1));
        end else if (up_ctrl.region == skv_pkg::R_LT2) begin
          s = p0;
        end
      end
      default: begin
      end
    endcase
    poly_next = s[SUM_W-1] ? '0 : s[POW_W-1:0];
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_poly <= poly_next;
    end
  end

endmodule

// File: rtl/core/skv_scale.sv
// normalization multiply, round half up and saturate into the output register
module skv_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic [FRAC_BITS+skv_pkg::POW_INT_BITS-1:0] up_poly,
  input  logic [skv_pkg::NORM_W-1:0]      norm_scale,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic [skv_pkg::OUT_W-1:0]       kernel_value,
  output logic                            saturated
);

  localparam int POW_W  = FRAC_BITS + skv_pkg::POW_INT_BITS;
  localparam int PROD_W = skv_pkg::NORM_W + POW_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int FULL_W = SUM_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_BITS - 1);

  logic              prod_valid;
  logic              prod_ready;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  round_sum;
  logic [FULL_W-1:0] full;
  logic              sat_next;

  assign up_ready   = !prod_valid || prod_ready;
  assign prod_ready = !dn_valid || dn_ready;

  assign round_sum = SUM_W'(prod) + HALF;
  assign full      = round_sum[SUM_W-1:FRAC_BITS];
  assign sat_next  = (full[FULL_W-1:skv_pkg::OUT_W] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      dn_valid   <= 1'b0;
    end else begin
      if (up_ready) begin
        prod_valid <= up_valid;
      end
      if (prod_ready) begin
        dn_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      prod <= PROD_W'(norm_scale) * PROD_W'(up_poly);
    end
    if (prod_valid && prod_ready) begin
      kernel_value <= sat_next ? '1 : full[skv_pkg::OUT_W-1:0];
      saturated    <= sat_next;
    end
  end

endmodule

// File: rtl/core/sph_kernel_value_unit.sv
// top level of the sph kernel value unit: config registers and the cell pipeline
//
//   channel   signals                                  width      beat
//   dist      dist_valid dist_ready dist_ratio         I+F        one distance q
//   kv        kv_valid kv_ready kernel_value saturated 40 + 1     one kernel value
//   cfg       cfg_we cfg_index cfg_data                1 + 32     one register write
//
// one beat per cycle sustained while kv is not stalled; dist to kv runs through the input stage,
// three multiply cells, polynomial combine, normalization multiply, round/saturate
// every stage has its own valid, so bubbles close up while kv is stalled
// reset clears all stage valids, sets kernel_type to cubic and norm_scale to 1.0
module sph_kernel_value_unit #(
  parameter int FRAC_BITS     = 16,
  parameter int DIST_INT_BITS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  dist_valid,
  output logic                                  dist_ready,
  input  logic [DIST_INT_BITS+FRAC_BITS-1:0]    dist_ratio,
  output logic                                  kv_valid,
  input  logic                                  kv_ready,
  output logic [skv_pkg::OUT_W-1:0]             kernel_value,
  output logic                                  saturated,
  input  logic                                  cfg_we,
  input  logic [skv_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [skv_pkg::NORM_W-1:0]            cfg_data
);

  localparam int BASE_W = FRAC_BITS + skv_pkg::BASE_INT_BITS;
  localparam int POW_W  = FRAC_BITS + skv_pkg::POW_INT_BITS;
  localparam int KT_W   = $bits(skv_pkg::kernel_t);
  localparam int STEPS  = skv_pkg::NUM_STEPS;

  skv_pkg::kernel_t            kernel_type;
  logic [skv_pkg::NORM_W-1:0]  norm_scale;

  logic                        chain_valid [STEPS+1];
  logic                        chain_ready [STEPS+1];
  skv_pkg::skv_ctrl_t          chain_ctrl  [STEPS+1];
  logic [BASE_W-1:0]           chain_q     [STEPS+1];
  logic [skv_pkg::NUM_LANES-1:0][BASE_W-1:0] chain_base [STEPS];
  logic [skv_pkg::NUM_LANES-1:0][POW_W-1:0]  chain_pow  [STEPS+1];

  logic                        poly_valid;
  logic                        poly_ready;
  logic [POW_W-1:0]            poly;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_type <= skv_pkg::K_CUBIC;
      norm_scale  <= skv_pkg::NORM_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        skv_pkg::REG_KERNEL_TYPE: kernel_type <= skv_pkg::kernel_t'(cfg_data[KT_W-1:0]);
        skv_pkg::REG_NORM_SCALE:  norm_scale  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  skv_prep #(
    .FRAC_BITS     (FRAC_BITS),
    .DIST_INT_BITS (DIST_INT_BITS)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (dist_valid),
    .up_ready    (dist_ready),
    .up_q        (dist_ratio),
    .kernel_type (kernel_type),
    .dn_valid    (chain_valid[0]),
    .dn_ready    (chain_ready[0]),
    .dn_ctrl     (chain_ctrl[0]),
    .dn_q        (chain_q[0]),
    .dn_base     (chain_base[0]),
    .dn_pow      (chain_pow[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    if (i < STEPS - 1) begin : g_mid
      skv_cell #(
        .FRAC_BITS (FRAC_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (chain_valid[i]),
        .up_ready (chain_ready[i]),
        .up_ctrl  (chain_ctrl[i]),
        .up_q     (chain_q[i]),
        .up_base  (chain_base[i]),
        .up_pow   (chain_pow[i]),
        .dn_valid (chain_valid[i+1]),
        .dn_ready (chain_ready[i+1]),
        .dn_ctrl  (chain_ctrl[i+1]),
        .dn_q     (chain_q[i+1]),
        .dn_base  (chain_base[i+1]),
        .dn_pow   (chain_pow[i+1])
      );
    end else begin : g_last
      skv_cell #(
        .FRAC_BITS (FRAC_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .up_valid (chain_valid[i]),
        .up_ready (chain_ready[i]),
        .up_ctrl  (chain_ctrl[i]),
        .up_q     (chain_q[i]),
        .up_base  (chain_base[i]),
        .up_pow   (chain_pow[i]),
        .dn_valid (chain_valid[i+1]),
        .dn_ready (chain_ready[i+1]),
        .dn_ctrl  (chain_ctrl[i+1]),
        .dn_q     (chain_q[i+1]),
        .dn_base  (),
        .dn_pow   (chain_pow[i+1])
      );
    end
  end

  skv_combine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_combine (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[STEPS]),
    .up_ready (chain_ready[STEPS]),
    .up_ctrl  (chain_ctrl[STEPS]),
    .up_q     (chain_q[STEPS]),
    .up_pow   (chain_pow[STEPS]),
    .dn_valid (poly_valid),
    .dn_ready (poly_ready),
    .dn_poly  (poly)
  );

  skv_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (poly_valid),
    .up_ready     (poly_ready),
    .up_poly      (poly),
    .norm_scale   (norm_scale),
    .dn_valid     (kv_valid),
    .dn_ready     (kv_ready),
    .kernel_value (kernel_value),
    .saturated    (saturated)
  );

`ifndef SYNTHESIS
  // pipeline comes out of reset empty and open
  assert property (@(posedge clk) rst |=> (!kv_valid && dist_ready))
    else $error("pipeline not empty after reset");

  // an open output opens the whole ready chain
  assert property (@(posedge clk) disable iff (rst) (!kv_valid || kv_ready) |-> dist_ready)
    else $error("dist_ready low while kv can move");

  // polynomial bound keeps the scaled value inside the output range
  assert property (@(posedge clk) disable iff (rst) kv_valid |-> !saturated)
    else $error("kernel value saturated");
`endif

endmodule
